// ----- design/sps_pkg.sv -----
package sps_pkg;

    localparam int unsigned DELAY_W = 24;
    localparam int unsigned SPR_W   = 16;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned COIL_W  = 4;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned BIT_CNT_W = 4;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd1000;
    localparam logic [SPR_W-1:0]   SPR_RESET   = 16'd200;
    localparam logic [MODE_W-1:0]  MODE_RESET  = 2'd0;
    localparam logic [DELAY_W-1:0] ELAPSED_MAX = {DELAY_W{1'b1}};

    localparam logic [IDX_W-1:0] CFG_STEP_DELAY = 2'd0;
    localparam logic [IDX_W-1:0] CFG_STEPS_REV  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DRIVE_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HALF = 2'd2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    localparam logic [COIL_W-1:0] B1100 = 4'b1100;
    localparam logic [COIL_W-1:0] B0110 = 4'b0110;
    localparam logic [COIL_W-1:0] B0011 = 4'b0011;
    localparam logic [COIL_W-1:0] B1001 = 4'b1001;
    localparam logic [COIL_W-1:0] B1000 = 4'b1000;
    localparam logic [COIL_W-1:0] B0100 = 4'b0100;
    localparam logic [COIL_W-1:0] B0010 = 4'b0010;
    localparam logic [COIL_W-1:0] B0001 = 4'b0001;

    function automatic logic [COIL_W-1:0] coil_pattern(
        input logic [MODE_W-1:0] mode,
        input logic [2:0]        pos
    );
        logic [COIL_W-1:0] pat;
        pat = B1100;
        case (mode)
            MODE_WAVE: begin
                case (pos[1:0])
                    2'd0:    pat = B1000;
                    2'd1:    pat = B0100;
                    2'd2:    pat = B0010;
                    default: pat = B0001;
                endcase
            end
            MODE_HALF: begin
                case (pos)
                    3'd0:    pat = B1000;
                    3'd1:    pat = B1100;
                    3'd2:    pat = B0100;
                    3'd3:    pat = B0110;
                    3'd4:    pat = B0010;
                    3'd5:    pat = B0011;
                    3'd6:    pat = B0001;
                    default: pat = B1001;
                endcase
            end
            default: begin
                case (pos[1:0])
                    2'd0:    pat = B1100;
                    2'd1:    pat = B0110;
                    2'd2:    pat = B0011;
                    default: pat = B1001;
                endcase
            end
        endcase
        return pat;
    endfunction

endpackage

// ----- design/stepper_phase_sequencer_core.sv -----
// A result word is registered in the cycle after its input word is accepted.
// Throughput: one word per cycle unless stalled; the output register refills
// while the result is taken. After a write to steps_per_revolution, input
// stalls while a bit-serial unit reduces the position modulo the new size.
// Reset (aresetn low, synchronous): registers to defaults, state cleared.
module stepper_phase_sequencer_core
    import sps_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic signed [COUNT_W-1:0] s_step_count,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [COIL_W-1:0]         m_coils,
    output logic                      m_stepped,
    output logic signed [COUNT_W-1:0] m_pending,
    output logic [POS_W-1:0]          m_shaft_position,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    logic [DELAY_W-1:0] delay_reg;
    logic [SPR_W-1:0]   spr_reg;
    logic [MODE_W-1:0]  mode_reg;

    logic signed [COUNT_W-1:0] pending_reg, pending_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [POS_W-1:0]          rem_reg, rem_next;
    logic [DELAY_W-1:0]        elapsed_reg, elapsed_next;
    logic [COIL_W-1:0]         coil_reg, coil_next;

    logic                      mod_busy_reg;
    logic [BIT_CNT_W-1:0]      mod_cnt_reg;
    logic [POS_W-1:0]          mod_rem_reg;
    logic [SPR_W:0]            mod_trial;
    logic [SPR_W:0]            mod_step;

    logic                      out_valid_reg;
    logic [COIL_W-1:0]         out_coils_reg;
    logic                      out_stepped_reg;
    logic signed [COUNT_W-1:0] out_pending_reg;
    logic [POS_W-1:0]          out_pos_reg;

    logic                      accept;
    logic                      spr_write;
    logic [SPR_W:0]            spr_full;
    logic signed [COUNT_W:0]   sum;
    logic [DELAY_W-1:0]        elapsed_inc;
    logic                      do_step;
    logic [SPR_W:0]            rem_up;
    logic [SPR_W:0]            step_pos;

    assign s_ready   = !mod_busy_reg && (!out_valid_reg || m_ready);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign spr_write = cfg_valid && (cfg_index == CFG_STEPS_REV);

    assign m_valid          = out_valid_reg;
    assign m_coils          = out_coils_reg;
    assign m_stepped        = out_stepped_reg;
    assign m_pending        = out_pending_reg;
    assign m_shaft_position = out_pos_reg;

    // size 0 means 65536
    assign spr_full = (spr_reg == '0) ? {1'b1, {SPR_W{1'b0}}} : {1'b0, spr_reg};

    always_comb begin
        pending_next = pending_reg;
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        elapsed_next = elapsed_reg;
        coil_next    = coil_reg;
        do_step      = 1'b0;
        step_pos     = '0;

        sum         = {s_step_count[COUNT_W-1], s_step_count}
                    + {pending_reg[COUNT_W-1], pending_reg};
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                   : elapsed_reg + 1'b1;
        rem_up      = {1'b0, rem_reg} + 1'b1;

        if (s_func == FUNC_ADD) begin
            if (sum > $signed({2'b00, {(COUNT_W-1){1'b1}}})) begin
                pending_next = {1'b0, {(COUNT_W-1){1'b1}}};
            end else if (sum < $signed({2'b11, {(COUNT_W-1){1'b0}}})) begin
                pending_next = {1'b1, {(COUNT_W-1){1'b0}}};
            end else begin
                pending_next = sum[COUNT_W-1:0];
            end
        end else begin
            elapsed_next = elapsed_inc;
            if (pending_reg != '0 && elapsed_inc >= delay_reg) begin
                do_step      = 1'b1;
                elapsed_next = '0;
                if (!pending_reg[COUNT_W-1]) begin
                    step_pos     = (rem_up == spr_full) ? '0 : rem_up;
                    pending_next = pending_reg - 1'b1;
                end else begin
                    step_pos     = (rem_reg == '0) ? spr_full - 1'b1
                                                   : {1'b0, rem_reg} - 1'b1;
                    pending_next = pending_reg + 1'b1;
                end
                pos_next  = step_pos[POS_W-1:0];
                rem_next  = step_pos[POS_W-1:0];
                coil_next = coil_pattern(mode_reg, step_pos[2:0]);
            end
        end
    end

    // restoring remainder, one position bit per cycle, MSB first
    assign mod_trial = {mod_rem_reg, pos_reg[mod_cnt_reg]};
    assign mod_step  = (mod_trial >= spr_full) ? mod_trial - spr_full : mod_trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= DELAY_RESET;
            spr_reg      <= SPR_RESET;
            mode_reg     <= MODE_RESET;
            mod_busy_reg <= 1'b0;
            mod_cnt_reg  <= '0;
            mod_rem_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_STEP_DELAY: delay_reg <= cfg_data[DELAY_W-1:0];
                    CFG_STEPS_REV:  spr_reg   <= cfg_data[SPR_W-1:0];
                    CFG_DRIVE_MODE: mode_reg  <= cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (spr_write) begin
                mod_busy_reg <= 1'b1;
                mod_cnt_reg  <= {BIT_CNT_W{1'b1}};
                mod_rem_reg  <= '0;
            end else if (mod_busy_reg) begin
                mod_rem_reg <= mod_step[POS_W-1:0];
                mod_cnt_reg <= mod_cnt_reg - 1'b1;
                if (mod_cnt_reg == '0) begin
                    mod_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            pos_reg     <= '0;
            rem_reg     <= '0;
            elapsed_reg <= '0;
            coil_reg    <= '0;
        end else if (accept) begin
            pending_reg <= pending_next;
            pos_reg     <= pos_next;
            rem_reg     <= rem_next;
            elapsed_reg <= elapsed_next;
            coil_reg    <= coil_next;
        end else if (mod_busy_reg && !spr_write && mod_cnt_reg == '0) begin
            rem_reg <= mod_step[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_coils_reg   <= coil_next;
            out_stepped_reg <= do_step;
            out_pending_reg <= pending_next;
            out_pos_reg     <= pos_next;
        end
    end

endmodule
